// File: hdl/bpa_pkg.sv
// Package: constants, payload and control types for the buddy page allocator.
`default_nettype none
package bpa_pkg;

   localparam int NUM_PAGES = 4096;
   localparam int MAX_ORDER = 10;
   localparam int PAGE_W    = $clog2(NUM_PAGES);
   localparam int PTR_W     = PAGE_W + 1;
   localparam int SUM_W     = PTR_W + 1;
   localparam int ORD_W     = 4;
   localparam int NUM_LISTS = MAX_ORDER + 1;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [ORD_W-1:0] ord_type;

   localparam ptr_type NO_PAGE = PTR_W'(NUM_PAGES);

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOMEM    = 2'd1,
      ST_MISALIGN = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

   typedef struct packed {
      logic              action;
      logic [ORD_W-1:0]  block_order;
      logic [PAGE_W-1:0] page_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] block_index;
      logic [PTR_W-1:0]  free_total;
   } rsp_type;

   typedef struct packed {
      logic    in_use;
      logic    free_head;
      ord_type order;
   } meta_type;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_FIND,
      CMD_FREAD,
      CMD_FCHK,
      CMD_MREAD,
      CMD_MSEL,
      CMD_MSTEP,
      CMD_FPUSH,
      CMD_SPLIT,
      CMD_UREAD,
      CMD_UNLINK,
      CMD_PREAD,
      CMD_PUSH,
      CMD_PLINK
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic alloc_none;
      logic free_reject;
      logic range_ok;
      logic merge_ok;
      logic split_more;
      logic split_push;
      logic tgt_head;
   } flags_type;

endpackage
`default_nettype wire

// File: hdl/bpa_datapath.sv
// Datapath: page memories, free list heads, counters and request registers.
`default_nettype none
module bpa_datapath (
   input  logic               clock,
   input  logic               reset,
   input  bpa_pkg::cmd_type   cmd,
   input  bpa_pkg::req_type   req_data,
   input  logic               csr_we,
   input  bpa_pkg::ptr_type   csr_wdata,
   output bpa_pkg::flags_type flags,
   output bpa_pkg::rsp_type   rsp_data
);
   import bpa_pkg::*;

   meta_type meta_mem [NUM_PAGES];
   ptr_type  next_mem [NUM_PAGES];
   ptr_type  prev_mem [NUM_PAGES];

   meta_type meta_q_ff;
   ptr_type  next_q_ff;
   ptr_type  prev_q_ff;

   ptr_type  head_ff  [NUM_LISTS];
   ptr_type  count_ff [NUM_LISTS];
   ptr_type  pf_ff;
   ptr_type  zone_ff;
   logic [PAGE_W-1:0] clr_ff;

   logic       action_ff;
   ord_type    req_o_ff, o_ff, c_ff, tord_ff;
   ptr_type    p_ff, h_ff, tgt_ff, ph_ff;
   logic       force_ff;
   status_type status_ff;
   logic [PAGE_W-1:0] idx_ff;

   ptr_type    zone_eff, size_o, buddy, split_tgt;
   logic [SUM_W-1:0] buddy_end, blk_end, pf_sum;
   logic       found, ignore, misalign;
   ord_type    fc, c_dec, uo;
   logic       uvalid;

   logic              meta_we, next_we, prev_we, meta_re;
   logic [PAGE_W-1:0] meta_wa, next_wa, prev_wa, meta_ra;
   meta_type          meta_wd;
   ptr_type           next_wd, prev_wd;

   always_comb begin
      zone_eff  = (zone_ff < NO_PAGE) ? zone_ff : NO_PAGE;
      size_o    = PTR_W'(1) << o_ff;
      buddy     = p_ff ^ size_o;
      buddy_end = SUM_W'(buddy) + SUM_W'(size_o);
      blk_end   = SUM_W'(p_ff) + SUM_W'(size_o);
      pf_sum    = SUM_W'(pf_ff) + SUM_W'(size_o);
      c_dec     = c_ff - ORD_W'(1);
      split_tgt = h_ff + (PTR_W'(1) << c_dec);
      uo        = meta_q_ff.order;
      uvalid    = (uo <= ORD_W'(MAX_ORDER));
      found     = 1'b0;
      fc        = '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
         if (!found && (ORD_W'(i) >= o_ff) && (head_ff[i] < NO_PAGE)) begin
            found = 1'b1;
            fc    = ORD_W'(i);
         end
      end
      ignore   = (p_ff >= NO_PAGE) || !meta_q_ff.in_use || meta_q_ff.free_head;
      misalign = (o_ff > ORD_W'(MAX_ORDER)) || ((p_ff & (size_o - PTR_W'(1))) != '0) ||
                 (blk_end > SUM_W'(NUM_PAGES));
   end

   always_comb begin
      flags.clear_last  = (clr_ff == PAGE_W'(NUM_PAGES - 1));
      flags.is_free     = (action_ff == ACT_FREE);
      flags.alloc_none  = (o_ff > ORD_W'(MAX_ORDER)) || !found;
      flags.free_reject = ignore || misalign;
      flags.range_ok    = (o_ff < ORD_W'(MAX_ORDER)) && (buddy_end <= SUM_W'(zone_eff));
      flags.merge_ok    = meta_q_ff.free_head && (meta_q_ff.order == o_ff) &&
                          !meta_q_ff.in_use;
      flags.split_more  = (c_ff > req_o_ff);
      flags.split_push  = (tgt_ff < NO_PAGE);
      flags.tgt_head    = meta_q_ff.free_head;
   end

   always_comb begin
      meta_we = 1'b0;
      meta_wa = tgt_ff[PAGE_W-1:0];
      meta_wd = '{in_use: 1'b0, free_head: 1'b0, order: '0};
      next_we = 1'b0;
      next_wa = tgt_ff[PAGE_W-1:0];
      next_wd = head_ff[tord_ff];
      prev_we = 1'b0;
      prev_wa = tgt_ff[PAGE_W-1:0];
      prev_wd = NO_PAGE;
      meta_re = 1'b0;
      meta_ra = tgt_ff[PAGE_W-1:0];
      case (cmd)
         CMD_CLEAR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            meta_wd = '{in_use: 1'b1, free_head: 1'b0, order: '0};
         end
         CMD_FREAD: begin
            meta_re = 1'b1;
            meta_ra = p_ff[PAGE_W-1:0];
         end
         CMD_FCHK: begin
            meta_we = !(ignore || misalign);
            meta_wa = p_ff[PAGE_W-1:0];
            meta_wd = '{in_use: 1'b0, free_head: meta_q_ff.free_head,
                        order: meta_q_ff.order};
         end
         CMD_MREAD: begin
            meta_re = 1'b1;
            meta_ra = buddy[PAGE_W-1:0];
         end
         CMD_UREAD, CMD_PREAD: begin
            meta_re = 1'b1;
         end
         CMD_UNLINK: begin
            meta_we = 1'b1;
            meta_wd = '{in_use: force_ff | meta_q_ff.in_use, free_head: 1'b0, order: '0};
            next_we = uvalid && (prev_q_ff < NO_PAGE);
            next_wa = prev_q_ff[PAGE_W-1:0];
            next_wd = next_q_ff;
            prev_we = uvalid && (next_q_ff < NO_PAGE);
            prev_wa = next_q_ff[PAGE_W-1:0];
            prev_wd = prev_q_ff;
         end
         CMD_PUSH: begin
            meta_we = 1'b1;
            meta_wd = '{in_use: 1'b0, free_head: 1'b1, order: tord_ff};
            next_we = 1'b1;
            prev_we = 1'b1;
         end
         CMD_PLINK: begin
            prev_we = (ph_ff < NO_PAGE);
            prev_wa = ph_ff[PAGE_W-1:0];
            prev_wd = tgt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (meta_re) begin
         meta_q_ff <= meta_mem[meta_ra];
         next_q_ff <= next_mem[tgt_ff[PAGE_W-1:0]];
         prev_q_ff <= prev_mem[tgt_ff[PAGE_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ff[i]  <= NO_PAGE;
            count_ff[i] <= '0;
         end
         pf_ff   <= '0;
         zone_ff <= NO_PAGE;
         clr_ff  <= '0;
      end else begin
         if (csr_we) begin
            zone_ff <= csr_wdata;
         end
         case (cmd)
            CMD_CLEAR: begin
               clr_ff <= clr_ff + PAGE_W'(1);
            end
            CMD_FIND: begin
               if (!flags.alloc_none) begin
                  pf_ff <= (pf_ff > size_o) ? pf_ff - size_o : '0;
               end
            end
            CMD_FCHK: begin
               if (!(ignore || misalign)) begin
                  pf_ff <= (pf_sum > SUM_W'(NUM_PAGES)) ? NO_PAGE : pf_sum[PTR_W-1:0];
               end
            end
            CMD_UNLINK: begin
               if (uvalid) begin
                  if ((prev_q_ff >= NO_PAGE) && (head_ff[uo] == tgt_ff)) begin
                     head_ff[uo] <= next_q_ff;
                  end
                  if (count_ff[uo] != '0) begin
                     count_ff[uo] <= count_ff[uo] - PTR_W'(1);
                  end
               end
            end
            CMD_PUSH: begin
               head_ff[tord_ff]  <= tgt_ff;
               count_ff[tord_ff] <= count_ff[tord_ff] + PTR_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            action_ff <= req_data.action;
            req_o_ff  <= req_data.block_order;
            o_ff      <= req_data.block_order;
            p_ff      <= {1'b0, req_data.page_index};
            status_ff <= ST_OK;
            idx_ff    <= (req_data.action == ACT_FREE) ? req_data.page_index : '0;
         end
         CMD_FIND: begin
            if (flags.alloc_none) begin
               status_ff <= ST_NOMEM;
               idx_ff    <= '0;
            end else begin
               h_ff     <= head_ff[fc];
               tgt_ff   <= head_ff[fc];
               c_ff     <= fc;
               idx_ff   <= head_ff[fc][PAGE_W-1:0];
               force_ff <= 1'b1;
            end
         end
         CMD_FCHK: begin
            if (ignore) begin
               status_ff <= ST_IGNORED;
            end else if (misalign) begin
               status_ff <= ST_MISALIGN;
            end
         end
         CMD_MSEL: begin
            tgt_ff   <= buddy;
            force_ff <= 1'b0;
         end
         CMD_MSTEP: begin
            p_ff <= p_ff & buddy;
            o_ff <= o_ff + ORD_W'(1);
         end
         CMD_FPUSH: begin
            tgt_ff  <= p_ff;
            tord_ff <= o_ff;
            idx_ff  <= p_ff[PAGE_W-1:0];
         end
         CMD_SPLIT: begin
            c_ff    <= c_dec;
            tgt_ff  <= split_tgt;
            tord_ff <= c_dec;
         end
         CMD_PREAD: begin
            force_ff <= 1'b0;
         end
         CMD_PUSH: begin
            ph_ff <= head_ff[tord_ff];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data.status      = status_ff;
      rsp_data.block_index = idx_ff;
      rsp_data.free_total  = pf_ff;
   end

endmodule
`default_nettype wire

// File: hdl/bpa_control.sv
// Controller: sequences list walks, splits and merges as datapath commands.
`default_nettype none
module bpa_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  bpa_pkg::flags_type flags,
   output bpa_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_strobe
);
   import bpa_pkg::*;

   typedef enum logic [19:0] {
      S_CLEAR  = 20'h00001,
      S_IDLE   = 20'h00002,
      S_DECODE = 20'h00004,
      S_FIND   = 20'h00008,
      S_FREAD  = 20'h00010,
      S_FCHK   = 20'h00020,
      S_MRANGE = 20'h00040,
      S_MREAD  = 20'h00080,
      S_MCHK   = 20'h00100,
      S_MSTEP  = 20'h00200,
      S_FPUSH  = 20'h00400,
      S_SPLIT  = 20'h00800,
      S_SPLIT2 = 20'h01000,
      S_UREAD  = 20'h02000,
      S_UNLINK = 20'h04000,
      S_PREAD  = 20'h08000,
      S_PCHK   = 20'h10000,
      S_PUSH   = 20'h20000,
      S_PLINK  = 20'h40000,
      S_DONE   = 20'h80000
   } state_type;

   state_type state_ff, state_in;
   state_type uret_ff, uret_in;
   state_type pret_ff, pret_in;

   always_comb begin
      state_in = state_ff;
      uret_in  = uret_ff;
      pret_in  = pret_ff;
      cmd      = CMD_NOP;
      case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLEAR;
            if (flags.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd      = CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = flags.is_free ? S_FREAD : S_FIND;
         end
         S_FIND: begin
            cmd = CMD_FIND;
            if (flags.alloc_none) begin
               state_in = S_DONE;
            end else begin
               uret_in  = S_SPLIT;
               state_in = S_UREAD;
            end
         end
         S_FREAD: begin
            cmd      = CMD_FREAD;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            cmd      = CMD_FCHK;
            state_in = flags.free_reject ? S_DONE : S_MRANGE;
         end
         S_MRANGE: begin
            state_in = flags.range_ok ? S_MREAD : S_FPUSH;
         end
         S_MREAD: begin
            cmd      = CMD_MREAD;
            state_in = S_MCHK;
         end
         S_MCHK: begin
            cmd = CMD_MSEL;
            if (flags.merge_ok) begin
               uret_in  = S_MSTEP;
               state_in = S_UREAD;
            end else begin
               state_in = S_FPUSH;
            end
         end
         S_MSTEP: begin
            cmd      = CMD_MSTEP;
            state_in = S_MRANGE;
         end
         S_FPUSH: begin
            cmd      = CMD_FPUSH;
            pret_in  = S_DONE;
            state_in = S_PREAD;
         end
         S_SPLIT: begin
            if (flags.split_more) begin
               cmd      = CMD_SPLIT;
               state_in = S_SPLIT2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SPLIT2: begin
            if (flags.split_push) begin
               pret_in  = S_SPLIT;
               state_in = S_PREAD;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_UREAD: begin
            cmd      = CMD_UREAD;
            state_in = S_UNLINK;
         end
         S_UNLINK: begin
            cmd      = CMD_UNLINK;
            state_in = uret_ff;
         end
         S_PREAD: begin
            cmd      = CMD_PREAD;
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (flags.tgt_head) begin
               uret_in  = S_PUSH;
               state_in = S_UREAD;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            cmd      = CMD_PUSH;
            state_in = S_PLINK;
         end
         S_PLINK: begin
            cmd      = CMD_PLINK;
            state_in = pret_ff;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         uret_ff  <= S_DONE;
         pret_ff  <= S_DONE;
      end else begin
         state_ff <= state_in;
         uret_ff  <= uret_in;
         pret_ff  <= pret_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_DONE);

endmodule
`default_nettype wire

// File: hdl/buddy_page_allocator.sv
// Top level: buddy page allocator, controller plus datapath.
// From accept to strobe, a refused allocate passes decode and find, a refused free decode,
// read and check; an allocate unlinks the found block and splits it level by level, pushing
// each upper half (one already a list head is unlinked first); a free merges level by level
// with each free buddy, then pushes the result. One request at a time, next accept in the
// cycle after the strobe; results never wait. Reset clears the page table with busy high.
`default_nettype none
module buddy_page_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bpa_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bpa_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  bpa_pkg::ptr_type csr_wdata
);
   import bpa_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   bpa_control u_control (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .flags      (flags),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   bpa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .flags     (flags),
      .rsp_data  (rsp_data)
   );

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("result strobe longer than one cycle");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer accepted without going busy");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result strobe while idle");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.free_total <= PTR_W'(NUM_PAGES)))
      else $error("free page total out of range");

endmodule
`default_nettype wire

// File: tb/buddy_page_allocator_tb.sv
// Testbench: randomized alloc/free regression of the buddy page allocator against a local model.
`default_nettype none
module buddy_page_allocator_tb;
   import bpa_pkg::*;

   localparam int ITEM_REQ  = 0;
   localparam int ITEM_CFG  = 1;
   localparam int ITEM_LIVE = 2;

   typedef struct {
      int      kind;
      req_type req;
      ptr_type zone;
   } item_type;

   typedef struct {
      int unsigned page;
      int unsigned order;
   } block_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   ptr_type csr_wdata = '0;

   item_type  pending_items[$];
   rsp_type   expected_rsps[$];
   block_type live_blocks[$];

   bit          pg_in_use[NUM_PAGES];
   bit          pg_head[NUM_PAGES];
   int unsigned pg_order[NUM_PAGES];
   int unsigned pg_next[NUM_PAGES];
   int unsigned pg_prev[NUM_PAGES];
   int unsigned lst_head[NUM_LISTS];
   int unsigned lst_count[NUM_LISTS];
   int unsigned pages_avail;
   int unsigned zone_size;

   int errors;
   int accepted;
   int settle;
   int status_seen[4];

   buddy_page_allocator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
   endtask

   function automatic void unlink_block(int unsigned p);
      int unsigned o;
      int unsigned pr;
      int unsigned nx;
      o  = pg_order[p];
      pr = pg_prev[p];
      nx = pg_next[p];
      if (o <= MAX_ORDER) begin
         if (pr < NUM_PAGES) pg_next[pr] = nx;
         else if (lst_head[o] == p) lst_head[o] = nx;
         if (nx < NUM_PAGES) pg_prev[nx] = pr;
         if (lst_count[o] > 0) lst_count[o]--;
      end
      pg_head[p]  = 1'b0;
      pg_order[p] = 0;
   endfunction

   function automatic void push_block(int unsigned p, int unsigned o);
      int unsigned h;
      if (pg_head[p]) unlink_block(p);
      h = lst_head[o];
      pg_next[p] = h;
      pg_prev[p] = NUM_PAGES;
      if (h < NUM_PAGES) pg_prev[h] = p;
      lst_head[o] = p;
      lst_count[o]++;
      pg_head[p]   = 1'b1;
      pg_order[p]  = o;
      pg_in_use[p] = 1'b0;
   endfunction

   function automatic rsp_type serve_request(req_type r);
      int unsigned o;
      int unsigned p;
      int unsigned c;
      int unsigned h;
      int unsigned b;
      int unsigned edge_pg;
      rsp_type     res;
      o = r.block_order;
      p = r.page_index;
      res = '0;
      if (r.action == ACT_ALLOC) begin
         h = NUM_PAGES;
         c = o;
         if (o > MAX_ORDER) res.status = ST_NOMEM;
         else begin
            for (c = o; c <= MAX_ORDER; c++) begin
               h = lst_head[c];
               if (h < NUM_PAGES) break;
            end
            if (h >= NUM_PAGES) res.status = ST_NOMEM;
            else begin
               unlink_block(h);
               pg_in_use[h] = 1'b1;
               pages_avail = pages_avail > (1 << o) ? pages_avail - (1 << o) : 0;
               while (c > o) begin
                  c--;
                  b = h + (1 << c);
                  if (b < NUM_PAGES) push_block(b, c);
               end
               res.status = ST_OK;
               res.block_index = PAGE_W'(h);
            end
         end
      end else begin
         res.block_index = PAGE_W'(p);
         if (!pg_in_use[p] || pg_head[p]) res.status = ST_IGNORED;
         else if (o > MAX_ORDER || (p & ((1 << o) - 1)) != 0 || p + (1 << o) > NUM_PAGES)
            res.status = ST_MISALIGN;
         else begin
            edge_pg = zone_size < NUM_PAGES ? zone_size : NUM_PAGES;
            pages_avail += 1 << o;
            if (pages_avail > NUM_PAGES) pages_avail = NUM_PAGES;
            pg_in_use[p] = 1'b0;
            while (o < MAX_ORDER) begin
               b = p ^ (1 << o);
               if (b + (1 << o) > edge_pg) break;
               if (!pg_head[b] || pg_order[b] != o || pg_in_use[b]) break;
               unlink_block(b);
               p = p & b;
               o++;
            end
            push_block(p, o);
            res.status = ST_OK;
            res.block_index = PAGE_W'(p);
         end
      end
      res.free_total = PTR_W'(pages_avail);
      return res;
   endfunction

   // driver: present transfers, predict on acceptance, write the zone register when idle
   always @(posedge clock) begin
      logic     nx_start;
      logic     nx_we;
      req_type  nx_req;
      rsp_type  want;
      item_type it;
      int       k;
      nx_start = start;
      nx_we    = 1'b0;
      nx_req   = req_data;
      if (reset) begin
         nx_start = 1'b0;
         settle   = 0;
      end else begin
         if (start && !busy) begin
            want = serve_request(req_data);
            expected_rsps.push_back(want);
            accepted++;
            if (req_data.action == ACT_ALLOC && want.status == ST_OK)
               live_blocks.push_back('{want.block_index, req_data.block_order});
            nx_start = 1'b0;
         end
         settle = (expected_rsps.size() == 0 && !busy && !nx_start) ? settle + 1 : 0;
         if (!nx_start && pending_items.size() > 0) begin
            it = pending_items[0];
            if (it.kind == ITEM_CFG) begin
               if (settle > 12) begin
                  nx_we     = 1'b1;
                  csr_wdata <= it.zone;
                  zone_size = it.zone;
                  void'(pending_items.pop_front());
                  settle = 0;
               end
            end else if ((accepted > 600 && accepted < 900) || $urandom_range(99) >= 8) begin
               nx_req = it.req;
               if (it.kind == ITEM_LIVE && live_blocks.size() > 0) begin
                  k = $urandom_range(live_blocks.size() - 1);
                  nx_req.page_index = PAGE_W'(live_blocks[k].page);
                  nx_req.block_order = ORD_W'(($urandom_range(9) < 8 ||
                                                live_blocks[k].order == 0) ?
                                               live_blocks[k].order :
                                               $urandom_range(live_blocks[k].order - 1));
                  live_blocks.delete(k);
               end
               nx_start = 1'b1;
               void'(pending_items.pop_front());
            end
         end
      end
      start    <= nx_start;
      req_data <= nx_req;
      csr_we   <= nx_we;
   end

   // monitor: check each result transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) report("unexpected result", rsp_data.status, 0);
         else begin
            want = expected_rsps.pop_front();
            status_seen[want.status]++;
            if (rsp_data.status != want.status) report("status", rsp_data.status, want.status);
            if (rsp_data.block_index != want.block_index)
               report("block_index", rsp_data.block_index, want.block_index);
            if (rsp_data.free_total != want.free_total)
               report("free_total", rsp_data.free_total, want.free_total);
         end
      end
   end

   function automatic item_type mk(int kind, logic act, int unsigned ord, int unsigned pg);
      item_type it;
      it.kind = kind;
      it.req.action = act;
      it.req.block_order = ORD_W'(ord);
      it.req.page_index = PAGE_W'(pg);
      it.zone = '0;
      return it;
   endfunction

   function automatic item_type mk_cfg(int unsigned z);
      item_type it;
      it = mk(ITEM_CFG, ACT_ALLOC, 0, 0);
      it.zone = PTR_W'(z);
      return it;
   endfunction

   function automatic item_type mk_random();
      int unsigned r;
      int unsigned ord;
      r = $urandom_range(99);
      ord = $urandom_range(9) < 7 ? $urandom_range(3) : $urandom_range(15);
      if (r < 45) return mk(ITEM_REQ, ACT_ALLOC, ord, $urandom_range(4095));
      if (r < 85) return mk(ITEM_LIVE, ACT_FREE, ord, $urandom_range(4095));
      return mk(ITEM_REQ, ACT_FREE, $urandom_range(15), $urandom_range(4095));
   endfunction

   initial begin
      int unsigned zones[6];
      int z;
      int i;
      zones = '{4096, 1, 2048, 4095, 1537, 4096};
      for (i = 0; i < NUM_PAGES; i++) begin
         pg_in_use[i] = 1'b1;
         pg_head[i] = 1'b0;
         pg_order[i] = 0;
         pg_next[i] = 0;
         pg_prev[i] = 0;
      end
      for (i = 0; i < NUM_LISTS; i++) begin
         lst_head[i] = NUM_PAGES;
         lst_count[i] = 0;
      end
      pages_avail = 0;
      zone_size = NUM_PAGES;
      errors = 0;
      accepted = 0;
      settle = 0;
      status_seen = '{0, 0, 0, 0};

      pending_items.push_back(mk_cfg(4096));
      pending_items.push_back(mk(ITEM_REQ, ACT_ALLOC, 0, 4095));
      pending_items.push_back(mk(ITEM_REQ, ACT_ALLOC, 11, 0));
      pending_items.push_back(mk(ITEM_REQ, ACT_ALLOC, 15, 0));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 10, 0));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 10, 1024));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 10, 0));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 15, 4095));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 1, 4095));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 11, 2048));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 9, 2048));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 9, 2560));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 10, 3072));
      pending_items.push_back(mk(ITEM_REQ, ACT_ALLOC, 0, 0));
      pending_items.push_back(mk(ITEM_REQ, ACT_ALLOC, 10, 0));
      pending_items.push_back(mk(ITEM_REQ, ACT_ALLOC, 5, 4095));
      pending_items.push_back(mk(ITEM_LIVE, ACT_FREE, 0, 0));
      pending_items.push_back(mk(ITEM_LIVE, ACT_FREE, 0, 0));
      pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 0, 4095));

      for (z = 0; z < 6; z++) begin
         pending_items.push_back(mk_cfg(zones[z]));
         for (i = 0; i < 4; i++)
            pending_items.push_back(mk(ITEM_REQ, ACT_FREE, 10, i * 1024));
         for (i = 0; i < 272; i++) pending_items.push_back(mk_random());
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && expected_rsps.size() == 0);
      repeat (100) @(posedge clock);
      if (expected_rsps.size() != 0) report("results left over", expected_rsps.size(), 0);
      $display("requests accepted: %0d over %0d zone settings", accepted, 7);
      $display("results ok %0d, no memory %0d, misaligned %0d, ignored %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
